// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the memory bus decoder RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assert failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("assert failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/mmbd_pkg.sv =====
// Package for the memory bus decoder: transaction structs, codes and windows.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package mmbd_pkg;
    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_PRELOAD = 2'd2;
    localparam logic [1:0] CMD_RSVD    = 2'd3;
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_RSVD = 2'd3;
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISALIGN  = 2'd1;
    localparam logic [1:0] ST_ILLEGAL   = 2'd2;
    localparam logic [31:0] DATA_BASE  = 32'h2000_0000;
    localparam logic [31:0] INSTR_BASE = 32'h1000_0000;
    localparam logic [29:0] IN_PORT_W  = 30'h0C00_0000;  // 0x30000000 >> 2
    localparam logic [29:0] OUT_PORT_W = 30'h0C00_0001;  // 0x30000004 >> 2

    typedef struct packed {
        logic [1:0]  cmd;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [31:0] write_data;
        logic [7:0]  in_char;
        logic        in_eof;
    } t_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  status;
        logic        in_taken;
        logic        out_valid;
        logic [7:0]  out_char;
    } t_rsp;

    // Operation classes decided by the front end.
    typedef enum logic [2:0] {
        OP_NONE, OP_DREAD, OP_DWRITE, OP_IREAD, OP_IWRITE
    } t_op;

    // Classified transaction passed through the queue.
    typedef struct packed {
        t_op         op;
        logic [29:0] word;      // word index within the window
        logic [3:0]  lanes;     // byte enables, lane 3 = most significant
        logic [31:0] wdata;     // lane-aligned write data
        logic [1:0]  lo;        // address low bits for read alignment
        logic [1:0]  sz;
        t_rsp        rsp;       // complete result for non-memory operations
    } t_cls;
endpackage
`default_nettype wire

// ===== hw/rtl/mmbd_front.sv =====
// Front end: accepts bus transactions, checks and decodes them.
// Depends on mmbd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mmbd_front import mmbd_pkg::*; #(
    parameter int DATA_ADDR_BITS  = 16,
    parameter int INSTR_ADDR_BITS = 16
) (
    input  wire t_req i_req,
    output t_cls      o_cls
);
    logic [31:0] w_doff, w_ioff;
    logic        w_mis, w_in_d, w_in_i;
    logic [3:0]  w_lanes;
    logic [31:0] w_wal;
    logic [1:0]  w_end;

    assign w_doff = i_req.address - DATA_BASE;
    assign w_ioff = i_req.address - INSTR_BASE;
    assign w_in_d = (i_req.address >= DATA_BASE) && ((w_doff >> DATA_ADDR_BITS) == 32'd0);
    assign w_in_i = (i_req.address >= INSTR_BASE) && ((w_ioff >> INSTR_ADDR_BITS) == 32'd0);
    assign w_end  = i_req.address[1:0] + ((i_req.access_size == SZ_WORD) ? 2'd3 :
                    (i_req.access_size == SZ_HALF) ? 2'd1 : 2'd0);

    // Lanes and alignment, big-endian: byte offset 0 is lane 3.
    always_comb begin
        w_mis = 1'b0;
        case (i_req.access_size)
            SZ_BYTE: begin
                w_lanes = 4'b1000 >> i_req.address[1:0];
                w_wal   = {24'd0, i_req.write_data[7:0]} << (8 * (3 - i_req.address[1:0]));
            end
            SZ_HALF: begin
                w_mis   = i_req.address[0];
                w_lanes = i_req.address[1] ? 4'b0011 : 4'b1100;
                w_wal   = i_req.address[1] ? {16'd0, i_req.write_data[15:0]}
                                           : {i_req.write_data[15:0], 16'd0};
            end
            default: begin
                w_mis   = (i_req.address[1:0] != 2'd0);
                w_lanes = 4'b1111;
                w_wal   = i_req.write_data;
            end
        endcase
    end

    // Classification of one transaction.
    always_comb begin
        o_cls       = '0;
        o_cls.op    = OP_NONE;
        o_cls.lanes = w_lanes;
        o_cls.wdata = w_wal;
        o_cls.lo    = i_req.address[1:0];
        o_cls.sz    = i_req.access_size;
        if (i_req.cmd == CMD_PRELOAD) begin
            o_cls.lanes = 4'b1000 >> i_req.address[1:0];
            o_cls.wdata = {24'd0, i_req.write_data[7:0]} << (8 * (3 - i_req.address[1:0]));
            o_cls.word  = 30'(i_req.address >> 2);
            if ((i_req.address >> INSTR_ADDR_BITS) == 32'd0) begin
                o_cls.op = OP_IWRITE;
            end else begin
                o_cls.rsp.status = ST_ILLEGAL;
            end
        end else if (i_req.cmd == CMD_RSVD || i_req.access_size == SZ_RSVD) begin
            o_cls.rsp.status = ST_ILLEGAL;
        end else if (w_mis) begin
            o_cls.rsp.status = ST_MISALIGN;
        end else if (i_req.cmd == CMD_READ) begin
            if (w_in_d) begin
                o_cls.op   = OP_DREAD;
                o_cls.word = 30'(w_doff >> 2);
            end else if (w_in_i) begin
                o_cls.op   = OP_IREAD;
                o_cls.word = 30'(w_ioff >> 2);
            end else if (i_req.address[31:2] == IN_PORT_W) begin
                o_cls.rsp.in_taken = 1'b1;
                if (i_req.in_eof) begin
                    o_cls.rsp.read_data = (i_req.access_size == SZ_WORD) ? 32'hFFFF_FFFF :
                        (i_req.access_size == SZ_HALF) ? 32'h0000_FFFF : 32'h0000_00FF;
                end else if (w_end == 2'd3) begin
                    o_cls.rsp.read_data = {24'd0, i_req.in_char};
                end
            end else begin
                o_cls.rsp.status = ST_ILLEGAL;
            end
        end else begin
            if (w_in_d) begin
                o_cls.op   = OP_DWRITE;
                o_cls.word = 30'(w_doff >> 2);
            end else if (i_req.address[31:2] == OUT_PORT_W) begin
                o_cls.rsp.out_valid = 1'b1;
                if (w_end == 2'd3) begin
                    o_cls.rsp.out_char = i_req.write_data[7:0];
                end
            end else begin
                o_cls.rsp.status = ST_ILLEGAL;
            end
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/mmbd_queue.sv =====
// Two-entry queue between the front end and the memory back end.
// Depends on mmbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mmbd_queue import mmbd_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cls i_cls,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_cls      o_cls
);
    t_cls       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cls   = r_q[r_rp];

    // Payload storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cls;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `ASSERT_CLK(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3)
endmodule
`default_nettype wire

// ===== hw/rtl/mmbd_back.sv =====
// Back end: data and instruction memories, clearing sweep and result register.
// Depends on mmbd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module mmbd_back import mmbd_pkg::*; #(
    parameter int DATA_ADDR_BITS  = 16,
    parameter int INSTR_ADDR_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_empty,
    input  wire t_cls i_cls,
    output logic      o_pop,
    output logic      o_busy,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);
    localparam int DW = DATA_ADDR_BITS - 2;
    localparam int IW = INSTR_ADDR_BITS - 2;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_HOLD} t_state;

    logic [31:0] r_dmem [2**DW];
    logic [31:0] r_imem [2**IW];
    t_state      r_state;
    logic [DW:0] r_clr;
    logic [31:0] r_rdata;
    t_cls        r_cur;
    t_rsp        r_rsp;
    logic        r_valid;
    logic [31:0] w_word, w_sh;
    logic        w_out_free;
    t_rsp        w_rsp;

    assign w_out_free = !r_valid || !i_stall;
    assign o_pop  = (r_state == S_IDLE) && !i_empty && w_out_free;
    assign o_busy = (r_state == S_CLEAR);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    // Memory ports: one write per memory and a single registered read from either memory per cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            r_dmem[r_clr[DW-1:0]] <= 32'd0;
        end else if (r_state == S_READ && r_cur.op == OP_DWRITE) begin
            for (int b = 0; b < 4; b++) begin
                if (r_cur.lanes[b]) r_dmem[r_cur.word[DW-1:0]][8*b +: 8] <= r_cur.wdata[8*b +: 8];
            end
        end
        if (r_state == S_READ && r_cur.op == OP_IWRITE) begin
            for (int b = 0; b < 4; b++) begin
                if (r_cur.lanes[b]) r_imem[r_cur.word[IW-1:0]][8*b +: 8] <= r_cur.wdata[8*b +: 8];
            end
        end
        if (o_pop) begin
            r_rdata <= (i_cls.op == OP_IREAD) ? r_imem[i_cls.word[IW-1:0]]
                                              : r_dmem[i_cls.word[DW-1:0]];
        end
    end

    // Extraction of the addressed bytes, zero-extended.
    always_comb begin
        w_sh = r_rdata << (8 * r_cur.lo);
        case (r_cur.sz)
            SZ_BYTE: w_word = {24'd0, w_sh[31:24]};
            SZ_HALF: w_word = {16'd0, w_sh[31:16]};
            default: w_word = r_rdata;
        endcase
    end

    // Result of the current transaction: memory reads take the extracted data.
    always_comb begin
        w_rsp = r_cur.rsp;
        if (r_cur.op == OP_DREAD || r_cur.op == OP_IREAD) begin
            w_rsp.read_data = w_word;
        end
    end

    // Sequencer: clear sweep, then each transaction in turn through S_IDLE and S_READ.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall) r_valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr[DW-1:0] == '1) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_cur   <= i_cls;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_rsp   <= w_rsp;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `ASSERT_NEVER(a_no_pop_in_clear, i_clk, i_rst_n, o_pop && o_busy)
    `ASSERT_CLK(a_valid_follows, i_clk, i_rst_n, (r_state == S_READ) |=> r_valid)
    `ASSERT_NEVER(a_no_hold, i_clk, i_rst_n, r_state == S_HOLD)
endmodule
`default_nettype wire

// ===== hw/rtl/memory_map_bus_decoder_unit.sv =====
// Memory bus decoder for a big-endian emulated processor.
// Input channel i_req_valid/o_req_stall carries one access transaction
// (read, write or instruction-byte preload); output channel
// o_rsp_valid/i_rsp_stall returns exactly one result per transaction.
// The front end checks alignment and decodes windows in the accept cycle;
// a two-entry queue decouples it from the memory back end.
// The back end handles one transaction at a time: a registered RAM read, then
// byte extraction and merge into the result register; it pops the next one
// only from S_IDLE while the result register is free. With an empty queue and
// no stall, a transaction passes the queue entry, the read register and the
// result register; each one waiting ahead in the queue goes through first.
// After reset the data RAM is swept to zero, one word per cycle; o_req_stall
// is high during the sweep. When the receiver stalls, the result holds; the
// queue then fills and o_req_stall rises. Instruction memory is undefined
// until preloaded.
// Depends on mmbd_pkg, mmbd_front, mmbd_queue and mmbd_back.
`timescale 1ns / 1ps
`default_nettype none
module memory_map_bus_decoder_unit import mmbd_pkg::*; #(
    parameter int DATA_ADDR_BITS  = 16,
    parameter int INSTR_ADDR_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_stall,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_stall,
    output t_rsp      o_rsp
);
    t_cls w_cls, w_qcls;
    logic w_full, w_empty, w_pop, w_busy, w_push;

    assign o_req_stall = w_full || w_busy;
    assign w_push      = i_req_valid && !o_req_stall;

    mmbd_front #(.DATA_ADDR_BITS(DATA_ADDR_BITS), .INSTR_ADDR_BITS(INSTR_ADDR_BITS)) u_front (
        .i_req(i_req), .o_cls(w_cls)
    );

    mmbd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cls(w_cls),
        .o_full(w_full), .i_pop(w_pop), .o_empty(w_empty), .o_cls(w_qcls)
    );

    mmbd_back #(.DATA_ADDR_BITS(DATA_ADDR_BITS), .INSTR_ADDR_BITS(INSTR_ADDR_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(w_empty), .i_cls(w_qcls),
        .o_pop(w_pop), .o_busy(w_busy), .o_valid(o_rsp_valid),
        .i_stall(i_rsp_stall), .o_rsp(o_rsp)
    );
endmodule
`default_nettype wire

// ===== bench/memory_map_bus_decoder_unit_checker.sv =====
// Checker for the memory bus decoder: predicts each result from accepted requests.
// Depends on mmbd_pkg; watches both channels of memory_map_bus_decoder_unit.
`timescale 1ns / 1ps
module memory_map_bus_decoder_unit_checker import mmbd_pkg::*; #(
    parameter int DATA_ADDR_BITS  = 16,
    parameter int INSTR_ADDR_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    input  wire logic i_req_stall,
    input  wire t_req i_req,
    input  wire logic i_rsp_valid,
    input  wire logic i_rsp_stall,
    input  wire t_rsp i_rsp,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_rsp_count
);
    localparam int DATA_WORDS  = 1 << (DATA_ADDR_BITS - 2);
    localparam int INSTR_WORDS = 1 << (INSTR_ADDR_BITS - 2);
    localparam logic [31:0] DATA_SIZE  = 32'd1 << DATA_ADDR_BITS;
    localparam logic [31:0] INSTR_SIZE = 32'd1 << INSTR_ADDR_BITS;

    logic [31:0] data_mem [DATA_WORDS];
    logic [31:0] instr_mem [INSTR_WORDS];
    t_rsp expected_rsps [$];

    initial begin
        o_fail_count = 0;
        o_rsp_count = 0;
        foreach (data_mem[k]) data_mem[k] = '0;
        foreach (instr_mem[k]) instr_mem[k] = '0;
    end

    assign o_pending = expected_rsps.size();

    // Big-endian byte access into a word array; byte offset 0 is the top byte.
    function automatic logic [7:0] mem_byte(input logic is_data, input logic [31:0] off);
        logic [31:0] w;
        w = is_data ? data_mem[(off >> 2) % DATA_WORDS] : instr_mem[(off >> 2) % INSTR_WORDS];
        return w[(3 - off[1:0]) * 8 +: 8];
    endfunction

    task automatic put_byte(input logic is_data, input logic [31:0] off, input logic [7:0] v);
        if (is_data) data_mem[(off >> 2) % DATA_WORDS][(3 - off[1:0]) * 8 +: 8] = v;
        else instr_mem[(off >> 2) % INSTR_WORDS][(3 - off[1:0]) * 8 +: 8] = v;
    endtask

    // Computes the result of one access and applies its side effects.
    task automatic predict_access(input t_req r, output t_rsp p);
        int n;
        logic [31:0] a;
        a = r.address;
        p = '0;
        n = 1 << r.access_size;
        if (r.cmd == CMD_PRELOAD) begin
            if (a < INSTR_SIZE) put_byte(1'b0, a, r.write_data[7:0]);
            else p.status = ST_ILLEGAL;
        end else if (r.cmd != CMD_READ && r.cmd != CMD_WRITE || r.access_size == SZ_RSVD) begin
            p.status = ST_ILLEGAL;
        end else if ((a & (n - 1)) != 0) begin
            p.status = ST_MISALIGN;
        end else if (r.cmd == CMD_READ) begin
            if (a >= DATA_BASE && a - DATA_BASE < DATA_SIZE) begin
                for (int i = 0; i < n; i++)
                    p.read_data = (p.read_data << 8) | mem_byte(1'b1, a - DATA_BASE + i);
            end else if (a >= INSTR_BASE && a - INSTR_BASE < INSTR_SIZE) begin
                for (int i = 0; i < n; i++)
                    p.read_data = (p.read_data << 8) | mem_byte(1'b0, a - INSTR_BASE + i);
            end else if (a[31:2] == IN_PORT_W) begin
                p.in_taken = 1'b1;
                if (r.in_eof) p.read_data = (n == 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 1);
                else if (a[1:0] + n == 4) p.read_data = {24'd0, r.in_char};
            end else begin
                p.status = ST_ILLEGAL;
            end
        end else begin
            if (a >= DATA_BASE && a - DATA_BASE < DATA_SIZE) begin
                for (int i = 0; i < n; i++)
                    put_byte(1'b1, a - DATA_BASE + i, r.write_data[8 * (n - 1 - i) +: 8]);
            end else if (a[31:2] == OUT_PORT_W) begin
                p.out_valid = 1'b1;
                if (a[1:0] + n == 4) p.out_char = r.write_data[7:0];
            end else begin
                p.status = ST_ILLEGAL;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_fail_count++;
        $display("mismatch on result %0d: %s got %h expected %h", o_rsp_count, what, got, want);
    endtask

    // Predict on each accepted request, compare each accepted result.
    always @(posedge i_clk) begin
        t_rsp p;
        t_rsp e;
        if (i_rst_n && i_req_valid && !i_req_stall) begin
            predict_access(i_req, p);
            expected_rsps.push_back(p);
        end
        if (i_rst_n && i_rsp_valid && !i_rsp_stall) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", 32'd1, 32'd0);
            end else begin
                e = expected_rsps.pop_front();
                if (i_rsp.read_data !== e.read_data)
                    report_mismatch("read_data", i_rsp.read_data, e.read_data);
                if (i_rsp.status !== e.status)
                    report_mismatch("status", i_rsp.status, e.status);
                if (i_rsp.in_taken !== e.in_taken)
                    report_mismatch("in_taken", i_rsp.in_taken, e.in_taken);
                if (i_rsp.out_valid !== e.out_valid)
                    report_mismatch("out_valid", i_rsp.out_valid, e.out_valid);
                if (i_rsp.out_char !== e.out_char)
                    report_mismatch("out_char", i_rsp.out_char, e.out_char);
            end
            o_rsp_count++;
        end
    end
endmodule

// ===== bench/memory_map_bus_decoder_unit_tb.sv =====
// Top of the memory bus decoder testbench: clock, reset, stimulus and verdict.
// Depends on mmbd_pkg, memory_map_bus_decoder_unit and its checker module.
`timescale 1ns / 1ps
module memory_map_bus_decoder_unit_tb;
    import mmbd_pkg::*;

    localparam int DATA_BITS  = 16;
    localparam int INSTR_BITS = 16;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int RANDOM_ITEMS = 1430;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    t_req req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b1;
    t_rsp rsp;
    int   fail_count, pending, rsp_count;
    int   idle_cycles = 0;
    int   sent = 0;
    bit   stim_done = 0;
    bit   hold_off = 0;
    bit   preloaded [bit [31:0]];

    initial forever #5 i_clk = ~i_clk;

    memory_map_bus_decoder_unit #(.DATA_ADDR_BITS(DATA_BITS), .INSTR_ADDR_BITS(INSTR_BITS)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .o_req_stall(req_stall), .i_req(req),
        .o_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall), .o_rsp(rsp)
    );

    memory_map_bus_decoder_unit_checker #(.DATA_ADDR_BITS(DATA_BITS),
                                          .INSTR_ADDR_BITS(INSTR_BITS)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(req_valid), .i_req_stall(req_stall), .i_req(req),
        .i_rsp_valid(rsp_valid), .i_rsp_stall(rsp_stall), .i_rsp(rsp),
        .o_fail_count(fail_count), .o_pending(pending), .o_rsp_count(rsp_count)
    );

    // Offer one transaction after a random gap unless no_gap is set, then hold it until accepted.
    task automatic send_access(input t_req r, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
        if (r.cmd == CMD_PRELOAD) preloaded[r.address] = 1;
    endtask

    // An instruction read is only legal when every byte it covers was preloaded.
    function automatic bit instr_ok(input logic [31:0] off, input int n);
        for (int i = 0; i < n; i++)
            if (!preloaded.exists(off + i)) return 0;
        return 1;
    endfunction

    function automatic t_req make_access(input logic [1:0] c, input logic [1:0] s,
                                         input logic [31:0] a, input logic [31:0] d);
        t_req r;
        r.cmd = c;
        r.access_size = s;
        r.address = a;
        r.write_data = d;
        r.in_char = $urandom;
        r.in_eof = $urandom_range(0, 3) == 0;
        return r;
    endfunction

    // Random access aimed mostly at mapped windows, sometimes anywhere.
    function automatic t_req random_access();
        t_req r;
        logic [31:0] a;
        logic [1:0] s;
        logic [1:0] c;
        int pick;
        s = $urandom_range(0, 9) == 0 ? SZ_RSVD : $urandom_range(0, 2);
        c = $urandom_range(0, 19) == 0 ? CMD_RSVD : $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        if (c == CMD_PRELOAD)
            a = pick < 90 ? $urandom_range(0, 255) : $urandom;
        else if (pick < 45)
            a = DATA_BASE + ($urandom_range(0, 63) << 2) + ($urandom_range(0, 3) & 3);
        else if (pick < 55)
            a = DATA_BASE + $urandom_range(0, (1 << DATA_BITS) - 1);
        else if (pick < 70)
            a = INSTR_BASE + $urandom_range(0, 255);
        else if (pick < 85)
            a = 32'h3000_0000 + $urandom_range(0, 7);
        else
            a = $urandom;
        if (pick < 80 && $urandom_range(0, 3) != 0)
            a = a & ~((32'd1 << (s == SZ_RSVD ? 0 : s)) - 1);
        r = make_access(c, s, a, $urandom);
        if (r.cmd == CMD_READ && r.access_size != SZ_RSVD &&
            (a & ((32'd1 << r.access_size) - 1)) == 0 &&
            a >= INSTR_BASE && a - INSTR_BASE < (32'd1 << INSTR_BITS) &&
            !instr_ok(a - INSTR_BASE, 1 << r.access_size))
            r.cmd = CMD_PRELOAD;
        if (r.cmd == CMD_PRELOAD && r.address >= INSTR_BASE) r.address = r.address - INSTR_BASE;
        return r;
    endfunction

    // Receiver: random stall per result, and one long hold-off on request.
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                rsp_stall <= 1'b1;
                repeat (60) @(negedge i_clk);
                hold_off = 0;
            end
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            if (wait_n != 0) begin
                rsp_stall <= 1'b1;
                repeat (wait_n) @(negedge i_clk);
            end
            rsp_stall <= 1'b0;
            @(posedge i_clk);
            while (!rsp_valid) @(posedge i_clk);
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending);
            $display("memory_map_bus_decoder_unit regression: fail");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Directed: extremes, every command, port lanes and faults.
        for (int i = 0; i < 4; i++)
            send_access(make_access(CMD_PRELOAD, SZ_BYTE, i, 32'hA5 + i), 0);
        send_access(make_access(CMD_PRELOAD, SZ_RSVD, (1 << INSTR_BITS) - 1, 32'hFF), 0);
        send_access(make_access(CMD_PRELOAD, SZ_BYTE, 1 << INSTR_BITS, 32'h11), 0);
        send_access(make_access(CMD_READ, SZ_WORD, INSTR_BASE, 0), 0);
        send_access(make_access(CMD_READ, SZ_BYTE, INSTR_BASE + (1 << INSTR_BITS) - 1, 0), 0);
        send_access(make_access(CMD_WRITE, SZ_WORD, INSTR_BASE, 32'h1234_5678), 0);
        send_access(make_access(CMD_WRITE, SZ_WORD, DATA_BASE, 32'hFFFF_FFFF), 0);
        send_access(make_access(CMD_WRITE, SZ_HALF, DATA_BASE + 2, 32'h0000_1234), 0);
        send_access(make_access(CMD_READ, SZ_WORD, DATA_BASE, 0), 0);
        send_access(make_access(CMD_WRITE, SZ_BYTE, DATA_BASE + (1 << DATA_BITS) - 1,
                                32'h5A), 0);
        send_access(make_access(CMD_READ, SZ_BYTE, DATA_BASE + (1 << DATA_BITS) - 1, 0), 0);
        send_access(make_access(CMD_READ, SZ_WORD, DATA_BASE + (1 << DATA_BITS), 0), 0);
        send_access(make_access(CMD_READ, SZ_HALF, DATA_BASE + 1, 0), 0);
        send_access(make_access(CMD_READ, SZ_WORD, DATA_BASE + 2, 0), 0);
        send_access(make_access(CMD_READ, SZ_BYTE, 32'h3000_0003, 0), 0);
        send_access(make_access(CMD_READ, SZ_HALF, 32'h3000_0002, 0), 0);
        send_access(make_access(CMD_READ, SZ_WORD, 32'h3000_0000, 0), 0);
        send_access(make_access(CMD_WRITE, SZ_BYTE, 32'h3000_0007, 32'hC3), 0);
        send_access(make_access(CMD_WRITE, SZ_BYTE, 32'h3000_0006, 32'hC3), 0);
        send_access(make_access(CMD_WRITE, SZ_WORD, 32'h3000_0000, 32'h1), 0);
        send_access(make_access(CMD_READ, SZ_WORD, 32'h3000_0004, 0), 0);
        send_access(make_access(CMD_RSVD, SZ_BYTE, DATA_BASE, 0), 0);
        send_access(make_access(CMD_READ, SZ_RSVD, DATA_BASE, 0), 0);
        send_access(make_access(CMD_WRITE, SZ_WORD, 32'hFFFF_FFFC, 32'hFFFF_FFFF), 0);
        // Random traffic; in the middle the receiver holds off while requests keep coming.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) hold_off = 1;
            send_access(random_access(), (i % 200) < 40 || hold_off);
        end
        req_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        $display("sent %0d accesses covering data, instruction, port and fault cases;",
                 sent);
        $display("%0d results compared, %0d mismatches", rsp_count, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("memory_map_bus_decoder_unit regression: pass");
        end else begin
            $display("memory_map_bus_decoder_unit regression: fail");
        end
        $finish;
    end
endmodule
